// File: src/bfpe_pkg.sv
package bfpe_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_EXEC  = 2'd2,
    REQ_STOP  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_ACK   = 3'd0,
    STAT_EXEC  = 3'd1,
    STAT_OUT   = 3'd2,
    STAT_IN    = 3'd3,
    STAT_IDLE  = 3'd4,
    STAT_FAULT = 3'd5
  } stat_e;

  typedef enum logic [2:0] {
    S_CLR_PROG,
    S_IDLE,
    S_CLR_CELL,
    S_FETCH,
    S_SCAN_F,
    S_SCAN_B
  } fsm_e;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;

endpackage

// File: src/bfpe_ram.sv
module bfpe_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bf_program_executor.sv
// channel   | signals                                        | handshake
// ----------+------------------------------------------------+-------------------------
// request   | req_type_i prog_addr_i prog_data_i in_char_i    | start && !busy
// result    | status_o out_char_o pc_now_o                   | done_o, one-cycle strobe
//
// write, stop and execute-while-idle give their result in the cycle after accept.
// a plain instruction first reads the program and cell stores, then decodes and
// writes the cell back. a bracket jump then scans the program store entry by entry.
// start clears the cell store one entry per cycle.
// after reset the program store is cleared one entry per cycle; busy stays high
// until the clear is done. the receiver cannot stall: each result shows once.
module bf_program_executor
  import bfpe_pkg::*;
#(
  parameter int PROG_DEPTH = 2048,
  parameter int CELL_DEPTH = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic [$clog2(PROG_DEPTH)-1:0] prog_addr_i,
  input  logic [7:0]                    prog_data_i,
  input  logic [7:0]                    in_char_i,
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [7:0]                    out_char_o,
  output logic [$clog2(PROG_DEPTH)-1:0] pc_now_o
);

  localparam int PA_W  = $clog2(PROG_DEPTH);
  localparam int CA_W  = $clog2(CELL_DEPTH);
  localparam int LVL_W = PA_W + 1;
  localparam logic [PA_W-1:0]  PLAST   = PA_W'(PROG_DEPTH - 1);
  localparam logic [CA_W-1:0]  CLAST   = CA_W'(CELL_DEPTH - 1);
  localparam logic [PA_W:0]    PDEPTH  = (PA_W + 1)'(PROG_DEPTH);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

  fsm_e             state_q, state_d;
  logic [PA_W-1:0]  pc_q, pc_d;
  logic [CA_W-1:0]  dp_q, dp_d;
  logic             run_q, run_d;
  logic [PA_W-1:0]  scan_q, scan_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [7:0]       inch_q, inch_d;
  logic             done_q, done_d;
  stat_e            stat_q, stat_d;
  logic [7:0]       och_q, och_d;
  logic [PA_W-1:0]  pcn_q, pcn_d;

  logic            p_we;
  logic [PA_W-1:0] p_waddr, p_raddr;
  logic [7:0]      p_wdata, op;
  logic            c_we;
  logic [CA_W-1:0] c_waddr;
  logic [7:0]      c_wdata, cell_rd;

  logic            acc;
  req_e            req;
  logic [PA_W-1:0] waddr_mod;
  logic            cell_zero;
  logic            hit;
  logic [7:0]      ch_open, ch_close;
  logic [CA_W-1:0] dp_inc, dp_dec;

  // shared address step unit
  logic [PA_W-1:0] step_a, step_r, step_w;
  logic            step_dn;

  bfpe_ram #(.DEPTH(PROG_DEPTH), .AW(PA_W), .DW(8)) u_prog (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (op)
  );

  bfpe_ram #(.DEPTH(CELL_DEPTH), .AW(CA_W), .DW(8)) u_cell (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (dp_q),
    .rdata_o (cell_rd)
  );

  assign busy      = (state_q != S_IDLE);
  assign acc       = start && (state_q == S_IDLE);
  assign req       = req_e'(req_type_i);
  assign cell_zero = (cell_rd == 8'd0);
  assign waddr_mod = ({1'b0, prog_addr_i} >= PDEPTH) ?
                     PA_W'({1'b0, prog_addr_i} - PDEPTH) : prog_addr_i;
  assign dp_inc    = (dp_q == CLAST) ? '0 : dp_q + CA_W'(1);
  assign dp_dec    = (dp_q == '0) ? CLAST : dp_q - CA_W'(1);
  assign ch_open   = (state_q == S_SCAN_F) ? CH_LBR : CH_RBR;
  assign ch_close  = (state_q == S_SCAN_F) ? CH_RBR : CH_LBR;
  assign hit       = ((state_q == S_SCAN_F) || (state_q == S_SCAN_B)) &&
                     (op == ch_close) && (lvl_q == LVL_ONE);

  assign step_a  = ((state_q == S_SCAN_F) || (state_q == S_SCAN_B) ||
                    (state_q == S_CLR_PROG)) ? scan_q : pc_q;
  assign step_dn = ((state_q == S_SCAN_B) && !hit) ||
                   ((state_q == S_FETCH) && (op == CH_RBR) && !cell_zero);
  assign step_r  = step_dn ? step_a - PA_W'(1) : step_a + PA_W'(1);
  assign step_w  = (!step_dn && (step_a == PLAST)) ? '0 : step_r;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR_PROG: begin
        if (scan_q == PLAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (req == REQ_START) state_d = S_CLR_CELL;
          else if (req == REQ_EXEC && run_q) state_d = S_FETCH;
        end
      end
      S_CLR_CELL: begin
        if (dp_q == CLAST) state_d = S_IDLE;
      end
      S_FETCH: begin
        if (op == CH_LBR && cell_zero && pc_q != PLAST) state_d = S_SCAN_F;
        else if (op == CH_RBR && !cell_zero && pc_q != '0) state_d = S_SCAN_B;
        else state_d = S_IDLE;
      end
      S_SCAN_F: begin
        if (hit || scan_q == PLAST) state_d = S_IDLE;
      end
      S_SCAN_B: begin
        if (hit || scan_q == '0) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    pc_d    = pc_q;
    dp_d    = dp_q;
    run_d   = run_q;
    scan_d  = scan_q;
    lvl_d   = lvl_q;
    inch_d  = inch_q;
    done_d  = 1'b0;
    stat_d  = stat_q;
    och_d   = och_q;
    p_we    = 1'b0;
    p_waddr = scan_q;
    p_wdata = 8'd0;
    p_raddr = pc_q;
    c_we    = 1'b0;
    c_waddr = dp_q;
    c_wdata = 8'd0;
    case (state_q)
      S_CLR_PROG: begin
        p_we   = 1'b1;
        scan_d = step_w;
      end
      S_IDLE: begin
        if (acc) begin
          inch_d = in_char_i;
          case (req)
            REQ_WRITE: begin
              p_we    = 1'b1;
              p_waddr = waddr_mod;
              p_wdata = prog_data_i;
              done_d  = 1'b1;
              stat_d  = STAT_ACK;
              och_d   = 8'd0;
            end
            REQ_START: begin
              pc_d  = '0;
              dp_d  = '0;
              run_d = 1'b1;
            end
            REQ_EXEC: begin
              if (!run_q) begin
                done_d = 1'b1;
                stat_d = STAT_IDLE;
                och_d  = 8'd0;
              end
            end
            REQ_STOP: begin
              run_d  = 1'b0;
              done_d = 1'b1;
              stat_d = STAT_ACK;
              och_d  = 8'd0;
            end
            default: begin
              done_d = 1'b0;
            end
          endcase
        end
      end
      S_CLR_CELL: begin
        c_we = 1'b1;
        dp_d = dp_inc;
        if (dp_q == CLAST) begin
          done_d = 1'b1;
          stat_d = STAT_ACK;
          och_d  = 8'd0;
        end
      end
      S_FETCH: begin
        done_d = 1'b1;
        stat_d = STAT_EXEC;
        och_d  = 8'd0;
        pc_d   = step_w;
        case (op)
          CH_RIGHT: dp_d = dp_inc;
          CH_LEFT:  dp_d = dp_dec;
          CH_INC: begin
            c_we    = 1'b1;
            c_wdata = cell_rd + 8'd1;
          end
          CH_DEC: begin
            c_we    = 1'b1;
            c_wdata = cell_rd - 8'd1;
          end
          CH_OUT: begin
            stat_d = STAT_OUT;
            och_d  = cell_rd;
          end
          CH_IN: begin
            c_we    = 1'b1;
            c_wdata = inch_q;
            stat_d  = STAT_IN;
          end
          CH_LBR: begin
            if (cell_zero) begin
              pc_d = pc_q;
              if (pc_q == PLAST) begin
                run_d  = 1'b0;
                stat_d = STAT_FAULT;
              end else begin
                done_d  = 1'b0;
                scan_d  = step_w;
                lvl_d   = LVL_ONE;
                p_raddr = step_w;
              end
            end
          end
          CH_RBR: begin
            if (!cell_zero) begin
              pc_d = pc_q;
              if (pc_q == '0) begin
                run_d  = 1'b0;
                stat_d = STAT_FAULT;
              end else begin
                done_d  = 1'b0;
                scan_d  = step_w;
                lvl_d   = LVL_ONE;
                p_raddr = step_w;
              end
            end
          end
          default: pc_d = step_w;
        endcase
      end
      S_SCAN_F, S_SCAN_B: begin
        if (hit) begin
          pc_d   = step_w;
          done_d = 1'b1;
          stat_d = STAT_EXEC;
          och_d  = 8'd0;
        end else if ((state_q == S_SCAN_F && scan_q == PLAST) ||
                     (state_q == S_SCAN_B && scan_q == '0)) begin
          run_d  = 1'b0;
          done_d = 1'b1;
          stat_d = STAT_FAULT;
          och_d  = 8'd0;
        end else begin
          scan_d  = step_w;
          p_raddr = step_w;
          if (op == ch_open) lvl_d = lvl_q + LVL_ONE;
          else if (op == ch_close) lvl_d = lvl_q - LVL_ONE;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  assign pcn_d = done_d ? pc_d : pcn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR_PROG;
      pc_q    <= '0;
      dp_q    <= '0;
      run_q   <= 1'b0;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      dp_q    <= dp_d;
      run_q   <= run_d;
      scan_q  <= scan_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    inch_q <= inch_d;
    stat_q <= stat_d;
    och_q  <= och_d;
    pcn_q  <= pcn_d;
  end

  assign done_o     = done_q;
  assign status_o   = stat_q;
  assign out_char_o = och_q;
  assign pc_now_o   = pcn_q;

endmodule
